/* design/json_number_recognizer_core_defines.svh */
// ----------------------------------------------------------------------------
// json_number_recognizer_core_defines
// Assertion macros shared by the modules of the JSON number recogniser.
// ----------------------------------------------------------------------------
`ifndef JSON_NUMBER_RECOGNIZER_CORE_DEFINES_SVH
`define JSON_NUMBER_RECOGNIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define JNR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define JNR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/jnr_pkg.sv */
// ----------------------------------------------------------------------------
// jnr_pkg
// Shared types and constants of the JSON number recogniser.
// ----------------------------------------------------------------------------
package jnr_pkg;

  // Default width of the length counter and result field.
  localparam int unsigned LENGTH_WIDTH_DEFAULT = 16;

  // Default depth of the queue between the classifier and the checker.
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // Result status codes.
  localparam logic STATUS_VALID     = 1'b0;
  localparam logic STATUS_MALFORMED = 1'b1;

  // Character classes, as seen by the grammar checker.
  typedef enum logic [3:0] {
    CC_MINUS,
    CC_PLUS,
    CC_ZERO,
    CC_DIGIT,
    CC_POINT,
    CC_EXP,
    CC_X,
    CC_OTHER,
    CC_EOI,
    CC_RERR
  } char_class_t;

  // One queued word between the classifier and the checker.
  typedef struct packed {
    char_class_t cls;
  } jnr_entry_t;

endpackage

/* design/jnr_front.sv */
// ----------------------------------------------------------------------------
// jnr_front
// Input side: takes character words and reduces each to a character class.
// ----------------------------------------------------------------------------
module jnr_front (
  input  logic                end_of_input,
  input  logic                read_error,
  input  logic [7:0]          char_code,
  output jnr_pkg::jnr_entry_t entry
);
  import jnr_pkg::*;

  localparam logic [7:0] ASC_MINUS = 8'h2d;
  localparam logic [7:0] ASC_PLUS  = 8'h2b;
  localparam logic [7:0] ASC_POINT = 8'h2e;
  localparam logic [7:0] ASC_ZERO  = 8'h30;
  localparam logic [7:0] ASC_NINE  = 8'h39;
  localparam logic [7:0] ASC_E_UP  = 8'h45;
  localparam logic [7:0] ASC_E_LO  = 8'h65;
  localparam logic [7:0] ASC_X_LO  = 8'h78;

  // A read error outranks an input end, which outranks the character itself.
  always_comb begin
    if (read_error) begin
      entry.cls = CC_RERR;
    end else if (end_of_input) begin
      entry.cls = CC_EOI;
    end else if (char_code == ASC_ZERO) begin
      entry.cls = CC_ZERO;
    end else if (char_code > ASC_ZERO && char_code <= ASC_NINE) begin
      entry.cls = CC_DIGIT;
    end else if (char_code == ASC_MINUS) begin
      entry.cls = CC_MINUS;
    end else if (char_code == ASC_PLUS) begin
      entry.cls = CC_PLUS;
    end else if (char_code == ASC_POINT) begin
      entry.cls = CC_POINT;
    end else if (char_code == ASC_E_UP || char_code == ASC_E_LO) begin
      entry.cls = CC_EXP;
    end else if (char_code == ASC_X_LO) begin
      entry.cls = CC_X;
    end else begin
      entry.cls = CC_OTHER;
    end
  end

endmodule

/* design/jnr_fifo.sv */
// ----------------------------------------------------------------------------
// jnr_fifo
// Short flop-based queue of classified words between front and back.
// ----------------------------------------------------------------------------
`include "json_number_recognizer_core_defines.svh"

module jnr_fifo #(
  parameter int unsigned DEPTH = jnr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  jnr_pkg::jnr_entry_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output jnr_pkg::jnr_entry_t rd_data
);
  import jnr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  jnr_entry_t        store [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  // Handshake on both sides of the queue.
  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = store[rd_ptr];

  // Storage is written only at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `JNR_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "queue count beyond depth")
  `JNR_ASSERT_NEXT(a_count_push, push && !pop, count == $past(count) + 1'b1, "count missed a push")

endmodule

/* design/jnr_back.sv */
// ----------------------------------------------------------------------------
// jnr_back
// Grammar checker: walks the number grammar one classified word at a time,
// counts characters and holds the result word until it is taken.
// ----------------------------------------------------------------------------
`include "json_number_recognizer_core_defines.svh"

module jnr_back #(
  parameter int unsigned LENGTH_WIDTH = jnr_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    entry_valid,
  output logic                    entry_ready,
  input  jnr_pkg::jnr_entry_t     entry,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic                    status,
  output logic [LENGTH_WIDTH-1:0] number_length
);
  import jnr_pkg::*;

  typedef enum logic [8:0] {
    PH_START   = 9'b000000001,
    PH_MINUS   = 9'b000000010,
    PH_ZERO    = 9'b000000100,
    PH_INT     = 9'b000001000,
    PH_POINT   = 9'b000010000,
    PH_FRAC    = 9'b000100000,
    PH_ESIGN   = 9'b001000000,
    PH_ESIGNED = 9'b010000000,
    PH_EXP     = 9'b100000000
  } phase_t;

  typedef enum logic [1:0] {
    ACT_GO,
    ACT_DONE,
    ACT_BAD
  } action_t;

  phase_t                  phase;
  phase_t                  phase_next;
  logic [LENGTH_WIDTH-1:0] char_count;
  action_t                 act;
  logic                    complete;
  logic                    is_dig;
  logic                    pop;
  char_class_t             cls;

  assign cls    = entry.cls;
  assign is_dig = (cls == CC_ZERO) || (cls == CC_DIGIT);

  // Phases in which the characters so far form a whole number.
  assign complete = (phase == PH_ZERO) || (phase == PH_INT) ||
                    (phase == PH_FRAC) || (phase == PH_EXP);

  // Decide what the current word does in the current phase.
  always_comb begin
    act        = ACT_BAD;
    phase_next = PH_START;
    if (cls == CC_RERR) begin
      act = ACT_BAD;
    end else if (cls == CC_EOI) begin
      act = complete ? ACT_DONE : ACT_BAD;
    end else begin
      case (phase)
        PH_MINUS: begin
          if (cls == CC_ZERO) begin
            act = ACT_GO; phase_next = PH_ZERO;
          end else if (cls == CC_DIGIT) begin
            act = ACT_GO; phase_next = PH_INT;
          end
        end
        PH_ZERO: begin
          if (cls == CC_POINT) begin
            act = ACT_GO; phase_next = PH_POINT;
          end else if (cls == CC_EXP) begin
            act = ACT_GO; phase_next = PH_ESIGN;
          end else if (is_dig || cls == CC_X) begin
            act = ACT_BAD;
          end else begin
            act = ACT_DONE;
          end
        end
        PH_INT: begin
          if (is_dig) begin
            act = ACT_GO; phase_next = PH_INT;
          end else if (cls == CC_POINT) begin
            act = ACT_GO; phase_next = PH_POINT;
          end else if (cls == CC_EXP) begin
            act = ACT_GO; phase_next = PH_ESIGN;
          end else begin
            act = ACT_DONE;
          end
        end
        PH_POINT: begin
          if (is_dig) begin
            act = ACT_GO; phase_next = PH_FRAC;
          end
        end
        PH_FRAC: begin
          if (is_dig) begin
            act = ACT_GO; phase_next = PH_FRAC;
          end else if (cls == CC_EXP) begin
            act = ACT_GO; phase_next = PH_ESIGN;
          end else begin
            act = ACT_DONE;
          end
        end
        PH_ESIGN: begin
          if (cls == CC_PLUS || cls == CC_MINUS) begin
            act = ACT_GO; phase_next = PH_ESIGNED;
          end else if (is_dig) begin
            act = ACT_GO; phase_next = PH_EXP;
          end
        end
        PH_ESIGNED: begin
          if (is_dig) begin
            act = ACT_GO; phase_next = PH_EXP;
          end
        end
        PH_EXP: begin
          if (is_dig) begin
            act = ACT_GO; phase_next = PH_EXP;
          end else begin
            act = ACT_DONE;
          end
        end
        default: begin
          // Start of a number, and any code outside the one-hot set.
          if (cls == CC_MINUS) begin
            act = ACT_GO; phase_next = PH_MINUS;
          end else if (cls == CC_ZERO) begin
            act = ACT_GO; phase_next = PH_ZERO;
          end else if (cls == CC_DIGIT) begin
            act = ACT_GO; phase_next = PH_INT;
          end
        end
      endcase
    end
  end

  // A word that yields a result needs the output register free or emptying.
  assign pop         = entry_valid && entry_ready;
  assign entry_ready = (act == ACT_GO) || !result_valid || result_ready;

  // Phase, counter and result flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      char_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (pop) begin
        if (act == ACT_GO) begin
          phase <= phase_next;
          if (char_count != '1) begin
            char_count <= char_count + 1'b1;
          end
        end else begin
          phase        <= PH_START;
          char_count   <= '0;
          result_valid <= 1'b1;
        end
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop && act != ACT_GO) begin
      status        <= (act == ACT_BAD) ? STATUS_MALFORMED : STATUS_VALID;
      number_length <= (act == ACT_BAD) ? '0 : char_count;
    end
  end

  `JNR_ASSERT_NOW(a_start_zero, phase == PH_START, char_count == '0, "count not clear at start")
  `JNR_ASSERT_NEXT(a_result_restart, pop && act != ACT_GO, phase == PH_START && result_valid,
    "result did not restart the checker")
  `JNR_ASSERT_NOW(a_bad_len, result_valid && status == STATUS_MALFORMED,
    number_length == '0, "malformed result with non-zero length")

endmodule

/* design/json_number_recognizer_core.sv */
// One character word is accepted per clock cycle while the queue has room. The word that ends a
// number is first stored in the four-word queue behind the classifier; the grammar checker then
// takes it from the head of the queue and writes the result word into its output register. The
// sustained rate of one word per cycle, when no result is held up, is set by the checker, which
// updates its phase and length counter for each word it takes. While a result waits to be taken,
// words that extend the next number still flow through; a word that would end it waits at the
// head of the queue, and the input stalls once three more words have queued behind it. The length
// saturates at 2^LENGTH_WIDTH - 1 and reads zero on a malformed result.
// ----------------------------------------------------------------------------
// json_number_recognizer_core
// Checks a character stream against the JSON number grammar and reports each
// number as complete with its length, or as malformed.
// ----------------------------------------------------------------------------
module json_number_recognizer_core #(
  parameter int unsigned LENGTH_WIDTH = jnr_pkg::LENGTH_WIDTH_DEFAULT,
  parameter int unsigned QUEUE_DEPTH  = jnr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    char_valid,
  output logic                    char_ready,
  input  logic [7:0]              character,
  input  logic                    end_of_input,
  input  logic                    read_error,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic                    status,
  output logic [LENGTH_WIDTH-1:0] number_length
);
  import jnr_pkg::*;

  jnr_entry_t front_entry;
  jnr_entry_t queue_entry;
  logic       queue_valid;
  logic       queue_ready;

  // Classifier on the input side.
  jnr_front u_front (
    .end_of_input (end_of_input),
    .read_error   (read_error),
    .char_code    (character),
    .entry        (front_entry)
  );

  // Queue that decouples the classifier from the checker.
  jnr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (char_valid),
    .wr_ready (char_ready),
    .wr_data  (front_entry),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_data  (queue_entry)
  );

  // Grammar checker and result register.
  jnr_back #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .entry_valid   (queue_valid),
    .entry_ready   (queue_ready),
    .entry         (queue_entry),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .status        (status),
    .number_length (number_length)
  );

endmodule

/* tb/jnr_number_checker.sv */
// ----------------------------------------------------------------------------
// jnr_number_checker
// Watches both channels of the JSON number recogniser, tracks the grammar
// phase and character count of the number being scanned, and compares every
// result word taken from the block with the oldest predicted one.
// ----------------------------------------------------------------------------
module jnr_number_checker #(
  parameter int unsigned LW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          char_valid,
  input  logic          char_ready,
  input  logic [7:0]    character,
  input  logic          end_of_input,
  input  logic          read_error,
  input  logic          result_valid,
  input  logic          result_ready,
  input  logic          status,
  input  logic [LW-1:0] number_length,
  output int unsigned   fail_count,
  output int unsigned   pending,
  output int unsigned   results_seen,
  output int unsigned   malformed_seen
);

  // Characters that steer the grammar.
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_E_LOW = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [LW-1:0] LENGTH_MAX = {LW{1'b1}};

  // Position within the number grammar.
  typedef enum logic [3:0] {
    SCAN_START,
    SCAN_MINUS,
    SCAN_ZERO,
    SCAN_INT,
    SCAN_POINT,
    SCAN_FRAC,
    SCAN_ESIGN,
    SCAN_ESIGNED,
    SCAN_EXP
  } scan_phase_t;

  // What one word does to the number being scanned.
  typedef enum logic [1:0] {
    STEP_EXTEND,
    STEP_FINISH,
    STEP_REJECT
  } scan_step_t;

  typedef struct packed {
    logic          status;
    logic [LW-1:0] length;
  } number_result_t;

  scan_phase_t    scan_phase;
  scan_phase_t    next_phase;
  scan_step_t     step;
  logic [LW-1:0]  char_count;
  number_result_t expected_results[$];
  number_result_t oldest;

  // Decides whether a character extends the number, completes it or breaks it.
  function automatic scan_step_t classify_char(input scan_phase_t ph, input logic [7:0] c,
                                               output scan_phase_t nxt);
    logic       dig;
    logic       ex;
    scan_step_t verdict;
    dig     = (c >= CH_ZERO) && (c <= CH_NINE);
    ex      = (c == CH_E_LOW) || (c == CH_E_UP);
    nxt     = SCAN_START;
    verdict = STEP_REJECT;
    case (ph)
      SCAN_MINUS: begin
        if (c == CH_ZERO) begin
          nxt = SCAN_ZERO;
          verdict = STEP_EXTEND;
        end else if (dig) begin
          nxt = SCAN_INT;
          verdict = STEP_EXTEND;
        end
      end
      SCAN_ZERO: begin
        if (c == CH_POINT) begin
          nxt = SCAN_POINT;
          verdict = STEP_EXTEND;
        end else if (ex) begin
          nxt = SCAN_ESIGN;
          verdict = STEP_EXTEND;
        end else if (!dig && c != CH_X) begin
          verdict = STEP_FINISH;
        end
      end
      SCAN_INT: begin
        verdict = STEP_EXTEND;
        if (dig) begin
          nxt = SCAN_INT;
        end else if (c == CH_POINT) begin
          nxt = SCAN_POINT;
        end else if (ex) begin
          nxt = SCAN_ESIGN;
        end else begin
          verdict = STEP_FINISH;
        end
      end
      SCAN_POINT: begin
        if (dig) begin
          nxt = SCAN_FRAC;
          verdict = STEP_EXTEND;
        end
      end
      SCAN_FRAC: begin
        verdict = STEP_EXTEND;
        if (dig) begin
          nxt = SCAN_FRAC;
        end else if (ex) begin
          nxt = SCAN_ESIGN;
        end else begin
          verdict = STEP_FINISH;
        end
      end
      SCAN_ESIGN: begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          nxt = SCAN_ESIGNED;
          verdict = STEP_EXTEND;
        end else if (dig) begin
          nxt = SCAN_EXP;
          verdict = STEP_EXTEND;
        end
      end
      SCAN_ESIGNED: begin
        if (dig) begin
          nxt = SCAN_EXP;
          verdict = STEP_EXTEND;
        end
      end
      SCAN_EXP: begin
        verdict = dig ? STEP_EXTEND : STEP_FINISH;
        nxt = SCAN_EXP;
      end
      default: begin
        if (c == CH_MINUS) begin
          nxt = SCAN_MINUS;
          verdict = STEP_EXTEND;
        end else if (c == CH_ZERO) begin
          nxt = SCAN_ZERO;
          verdict = STEP_EXTEND;
        end else if (dig) begin
          nxt = SCAN_INT;
          verdict = STEP_EXTEND;
        end
      end
    endcase
    return verdict;
  endfunction

  // Counts a failure and reports the first few of them.
  task automatic note_failure(input string what, input number_result_t want);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] %s: expected status %0b length %0d, got status %0b length %0d",
               $realtime, what, want.status, want.length, status, number_length);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scan_phase     = SCAN_START;
      char_count     = '0;
      fail_count     = 0;
      results_seen   = 0;
      malformed_seen = 0;
      expected_results.delete();
    end else begin
      // Predict the effect of each accepted character word.
      if (char_valid && char_ready) begin
        next_phase = SCAN_START;
        if (read_error) begin
          step = STEP_REJECT;
        end else if (end_of_input) begin
          step = (scan_phase inside {SCAN_ZERO, SCAN_INT, SCAN_FRAC, SCAN_EXP}) ?
                 STEP_FINISH : STEP_REJECT;
        end else begin
          step = classify_char(scan_phase, character, next_phase);
        end
        if (step == STEP_EXTEND) begin
          scan_phase = next_phase;
          if (char_count != LENGTH_MAX) begin
            char_count = char_count + 1'b1;
          end
        end else begin
          oldest.status = (step == STEP_REJECT) ? jnr_pkg::STATUS_MALFORMED
                                                : jnr_pkg::STATUS_VALID;
          oldest.length = (step == STEP_REJECT) ? '0 : char_count;
          expected_results.push_back(oldest);
          scan_phase = SCAN_START;
          char_count = '0;
        end
      end

      // Compare each accepted result word with the oldest prediction.
      if (result_valid && result_ready) begin
        results_seen++;
        if (status === jnr_pkg::STATUS_MALFORMED) begin
          malformed_seen++;
        end
        if (expected_results.size() == 0) begin
          oldest = '0;
          note_failure("result word with nothing expected", oldest);
        end else begin
          oldest = expected_results.pop_front();
          if (status !== oldest.status) begin
            note_failure("status mismatch", oldest);
          end
          if (number_length !== oldest.length) begin
            note_failure("length mismatch", oldest);
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

/* tb/tb_json_number_recognizer_core.sv */
// ----------------------------------------------------------------------------
// tb_json_number_recognizer_core
// Drives character words into the JSON number recogniser: a directed set of
// grammar corner cases, then well-formed numbers with random content mixed
// with corrupted numbers and noise. A separate checker predicts and compares
// every result word.
// ----------------------------------------------------------------------------
module tb_json_number_recognizer_core;

  localparam int unsigned LW           = jnr_pkg::LENGTH_WIDTH_DEFAULT;
  localparam int unsigned RANDOM_WORDS = 950;
  localparam int unsigned CYCLE_LIMIT  = 40000;
  localparam int unsigned SETTLE       = 8;

  logic          clk;
  logic          rst;
  logic          char_valid;
  logic          char_ready;
  logic [7:0]    character;
  logic          end_of_input;
  logic          read_error;
  logic          result_valid;
  logic          result_ready;
  logic          status;
  logic [LW-1:0] number_length;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned malformed_seen;

  int unsigned cycle_count;
  int unsigned words_sent;
  int unsigned burst_left;
  bit          gaps_on;
  int unsigned ready_tick;
  int unsigned ready_mode;
  logic [7:0]  token[$];

  json_number_recognizer_core #(
    .LENGTH_WIDTH (LW)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_ready    (char_ready),
    .character     (character),
    .end_of_input  (end_of_input),
    .read_error    (read_error),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .status        (status),
    .number_length (number_length)
  );

  jnr_number_checker #(
    .LW (LW)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .char_valid     (char_valid),
    .char_ready     (char_ready),
    .character      (character),
    .end_of_input   (end_of_input),
    .read_error     (read_error),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .status         (status),
    .number_length  (number_length),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .malformed_seen (malformed_seen)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("tb_json_number_recognizer_core failed");
      $finish;
    end
  end

  // The receiver switches between stall patterns every so often.
  always @(negedge clk) begin
    ready_tick++;
    if (ready_tick % 97 == 0) begin
      ready_mode = $urandom_range(0, 3);
    end
    case (ready_mode)
      0:       result_ready <= 1'b1;
      1:       result_ready <= 1'($urandom_range(0, 1));
      2:       result_ready <= (ready_tick % 4 == 0);
      default: result_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Offers one word and holds it until it is accepted; returns at a falling edge.
  task automatic send_word(input logic [7:0] c, input logic eoi, input logic rerr);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gaps_on && gap != 0) begin
        char_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    char_valid   <= 1'b1;
    character    <= c;
    end_of_input <= eoi;
    read_error   <= rerr;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], 1'b0, 1'b0);
    end
  endtask

  task automatic send_token();
    foreach (token[i]) begin
      send_word(token[i], 1'b0, 1'b0);
    end
  endtask

  // Holds the sender off until every predicted result has been taken.
  task automatic drain_results();
    char_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic push_digits(input int unsigned n);
    string digits;
    digits = "0123456789";
    repeat (n) token.push_back(digits[$urandom_range(0, 9)]);
  endtask

  // Builds one well-formed number with random content, sometimes corrupted.
  task automatic build_number();
    string exps;
    string signs;
    int unsigned spot;
    exps  = "eE";
    signs = "+-";
    token.delete();
    if ($urandom_range(0, 1)) token.push_back("-");
    if ($urandom_range(0, 3) == 0) begin
      token.push_back("0");
    end else begin
      token.push_back(8'(8'h31 + $urandom_range(0, 8)));
      push_digits(($urandom_range(0, 7) == 0) ? $urandom_range(5, 14) : $urandom_range(0, 3));
    end
    if ($urandom_range(0, 1)) begin
      token.push_back(".");
      push_digits($urandom_range(1, 4));
    end
    if ($urandom_range(0, 2) == 0) begin
      token.push_back(exps[$urandom_range(0, 1)]);
      if ($urandom_range(0, 1)) token.push_back(signs[$urandom_range(0, 1)]);
      push_digits($urandom_range(1, 3));
    end
    // A share of numbers are broken by a stray byte or cut short.
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        spot = $urandom_range(0, token.size() - 1);
        token[spot] = 8'($urandom_range(0, 255));
      end
      3, 4: begin
        spot = $urandom_range(1, token.size());
        while (token.size() > spot) void'(token.pop_back());
      end
      default: ;
    endcase
  endtask

  // Ends the current number in one of several ways.
  task automatic send_ending();
    string delims;
    delims = " ,]}\t\n";
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_word(delims[$urandom_range(0, 5)], 1'b0, 1'b0);
      4, 5:       send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      6, 7:       send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      8:          send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      default:    ;
    endcase
  endtask

  // Stimulus and verdict.
  initial begin
    rst          = 1'b1;
    char_valid   = 1'b0;
    character    = 8'h00;
    end_of_input = 1'b0;
    read_error   = 1'b0;
    words_sent   = 0;
    burst_left   = 0;
    gaps_on      = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corner cases of the grammar.
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_string("-0");
    send_word(8'h00, 1'b1, 1'b0);
    send_string("-");
    send_word(8'h00, 1'b1, 1'b0);
    send_string("-a");
    send_string("01");
    send_string("0x");
    send_string("0e+5 ");
    send_string("9.E");
    send_string("1e-");
    send_word(8'h00, 1'b1, 1'b0);
    send_string("12");
    send_word(8'h00, 1'b1, 1'b1);
    send_string("7.25E9,");
    drain_results();

    // Random numbers, corrupted numbers and noise.
    while (words_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_word(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                    ($urandom_range(0, 7) == 0));
        end
      end else begin
        build_number();
        send_token();
        send_ending();
      end
      if ($urandom_range(0, 60) == 0) drain_results();
    end
    drain_results();

    char_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Covered %0d words: grammar corner cases, random and broken numbers, noise.",
             words_sent);
    $display("Checked %0d result words, %0d of them malformed.", results_seen, malformed_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_json_number_recognizer_core passed");
    end else begin
      $display("tb_json_number_recognizer_core failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/jnr_pkg.sv
design/jnr_front.sv
design/jnr_fifo.sv
design/jnr_back.sv
design/json_number_recognizer_core.sv
tb/jnr_number_checker.sv
tb/tb_json_number_recognizer_core.sv
